>>> design/ptcp_pkg.sv
// Shared widths, types and region codes for the closest-point-on-triangle pipeline.
package ptcp_pkg;

  localparam int COORD_BITS = 16;
  localparam int WFB        = 16;
  localparam int OUT_BITS   = COORD_BITS + 2;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int DOT_BITS   = 2 * DIFF_BITS + 2;
  localparam int SIX_BITS   = DOT_BITS + 2;
  localparam int PROD_BITS  = 2 * DOT_BITS;
  localparam int REM_BITS   = PROD_BITS + 1;
  localparam int THR_BITS   = 40;
  localparam int WT_BITS    = WFB + 1;
  localparam int ACC_BITS   = COORD_BITS + WFB + 4;
  localparam int IN_BITS    = 12 * COORD_BITS;
  localparam int OUTD_BITS  = ((3 * OUT_BITS + 7) / 8) * 8;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(429497);

  localparam logic [2:0] REG_INTERIOR = 3'd0;
  localparam logic [2:0] REG_VERT_A   = 3'd1;
  localparam logic [2:0] REG_EDGE_AC  = 3'd2;
  localparam logic [2:0] REG_EDGE_AB  = 3'd3;
  localparam logic [2:0] REG_VERT_C   = 3'd4;
  localparam logic [2:0] REG_VERT_B   = 3'd5;
  localparam logic [2:0] REG_EDGE_BC  = 3'd6;

  typedef logic signed [DOT_BITS-1:0]  dot_t;
  typedef logic signed [SIX_BITS-1:0]  six_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] a;
    logic [2:0][DIFF_BITS-1:0]  e0;
    logic [2:0][DIFF_BITS-1:0]  e1;
  } geom_t;

  typedef struct packed {
    geom_t geom;
    dot_t  a;
    dot_t  c;
    dot_t  d;
    dot_t  e;
    six_t  num6;
    six_t  den6;
    prod_t det;
    prod_t s;
    prod_t t;
  } front_t;

  typedef struct packed {
    logic [REM_BITS-1:0] num;
    logic [REM_BITS-1:0] den;
    logic                force0;
    logic                force1;
  } lane_t;

  typedef struct packed {
    geom_t      geom;
    logic [2:0] region;
    logic       tw_from_sw;
  } side_t;

  typedef struct packed {
    logic [WFB-1:0] q;
    logic           force0;
    logic           force1;
  } quot_t;

endpackage

>>> design/ptcp_front.sv
// Front stages: edge vectors, dot products, wide products, determinant and numerators.
module ptcp_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [ptcp_pkg::IN_BITS-1:0]      in_data,
  output logic                              out_vld,
  output ptcp_pkg::front_t                  out_item
);
  import ptcp_pkg::*;

  function automatic dot_t dot3(input logic [2:0][DIFF_BITS-1:0] x,
                                input logic [2:0][DIFF_BITS-1:0] y);
    dot3 = dot_t'($signed(x[0])) * dot_t'($signed(y[0]))
         + dot_t'($signed(x[1])) * dot_t'($signed(y[1]))
         + dot_t'($signed(x[2])) * dot_t'($signed(y[2]));
  endfunction

  logic [3:0] vld;
  geom_t g1, g2, g3;
  logic [2:0][DIFF_BITS-1:0] dv1;
  dot_t a2, b2, c2, d2, e2;
  dot_t a3, b3, c3, d3, e3;
  prod_t ac3, bb3, be3, cd3, bd3, ae3;
  geom_t g1_next;
  logic [2:0][DIFF_BITS-1:0] dv1_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g1_next.a[k]  = in_data[k*COORD_BITS +: COORD_BITS];
      g1_next.e0[k] = DIFF_BITS'($signed(in_data[(3+k)*COORD_BITS +: COORD_BITS]))
                    - DIFF_BITS'($signed(in_data[k*COORD_BITS +: COORD_BITS]));
      g1_next.e1[k] = DIFF_BITS'($signed(in_data[(6+k)*COORD_BITS +: COORD_BITS]))
                    - DIFF_BITS'($signed(in_data[k*COORD_BITS +: COORD_BITS]));
      dv1_next[k]   = DIFF_BITS'($signed(in_data[k*COORD_BITS +: COORD_BITS]))
                    - DIFF_BITS'($signed(in_data[(9+k)*COORD_BITS +: COORD_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1  <= g1_next;
      dv1 <= dv1_next;
      g2  <= g1;
      a2  <= dot3(g1.e0, g1.e0);
      b2  <= dot3(g1.e0, g1.e1);
      c2  <= dot3(g1.e1, g1.e1);
      d2  <= dot3(g1.e0, dv1);
      e2  <= dot3(g1.e1, dv1);
      g3  <= g2;
      a3  <= a2;
      b3  <= b2;
      c3  <= c2;
      d3  <= d2;
      e3  <= e2;
      ac3 <= prod_t'(a2) * prod_t'(c2);
      bb3 <= prod_t'(b2) * prod_t'(b2);
      be3 <= prod_t'(b2) * prod_t'(e2);
      cd3 <= prod_t'(c2) * prod_t'(d2);
      bd3 <= prod_t'(b2) * prod_t'(d2);
      ae3 <= prod_t'(a2) * prod_t'(e2);
      out_item.geom <= g3;
      out_item.a    <= a3;
      out_item.c    <= c3;
      out_item.d    <= d3;
      out_item.e    <= e3;
      out_item.num6 <= six_t'(c3) + six_t'(e3) - six_t'(b3) - six_t'(d3);
      out_item.den6 <= six_t'(a3) - (six_t'(b3) <<< 1) + six_t'(c3);
      out_item.det  <= ac3 - bb3;
      out_item.s    <= be3 - cd3;
      out_item.t    <= bd3 - ae3;
    end
  end

  assign out_vld = vld[3];
endmodule

>>> design/ptcp_region.sv
// Region choice and divider set-up for both weights.
module ptcp_region (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [ptcp_pkg::THR_BITS-1:0]  thr,
  input  logic                           in_vld,
  input  ptcp_pkg::front_t               in_item,
  output logic                           out_vld,
  output ptcp_pkg::side_t                out_side,
  output ptcp_pkg::lane_t [1:0]          out_req
);
  import ptcp_pkg::*;

  logic signed [REM_BITS-1:0] st, detx, thrx;
  logic inner;
  dot_t neg_d, neg_e;
  side_t side_next;
  lane_t [1:0] req_next;

  always_comb begin
    st    = REM_BITS'(in_item.s) + REM_BITS'(in_item.t);
    detx  = REM_BITS'(in_item.det);
    thrx  = $signed({{(REM_BITS-THR_BITS){1'b0}}, thr});
    inner = !(detx < st) && (thrx < detx);
    neg_d = -in_item.d;
    neg_e = -in_item.e;
    side_next.geom       = in_item.geom;
    side_next.tw_from_sw = 1'b0;
    for (int l = 0; l < 2; l++) begin
      req_next[l].num    = '0;
      req_next[l].den    = {{(REM_BITS-1){1'b0}}, 1'b1};
      req_next[l].force0 = 1'b1;
      req_next[l].force1 = 1'b0;
    end
    if (inner) begin
      if (in_item.s[PROD_BITS-1]) begin
        if (in_item.t[PROD_BITS-1]) begin
          side_next.region = REG_VERT_A;
        end else begin
          side_next.region = REG_EDGE_AC;
          req_next[1].num    = {{(REM_BITS-DOT_BITS){1'b0}}, neg_e};
          req_next[1].den    = {{(REM_BITS-DOT_BITS){1'b0}}, in_item.c};
          req_next[1].force0 = !in_item.e[DOT_BITS-1];
          req_next[1].force1 = in_item.e[DOT_BITS-1] && (neg_e >= in_item.c);
        end
      end else if (in_item.t[PROD_BITS-1]) begin
        side_next.region = REG_EDGE_AB;
        req_next[0].num    = {{(REM_BITS-DOT_BITS){1'b0}}, neg_d};
        req_next[0].den    = {{(REM_BITS-DOT_BITS){1'b0}}, in_item.a};
        req_next[0].force0 = !in_item.d[DOT_BITS-1];
        req_next[0].force1 = in_item.d[DOT_BITS-1] && (neg_d >= in_item.a);
      end else begin
        side_next.region = REG_INTERIOR;
        req_next[0].num    = {1'b0, in_item.s};
        req_next[0].den    = {1'b0, in_item.det};
        req_next[0].force0 = 1'b0;
        req_next[0].force1 = !(in_item.s < in_item.det);
        req_next[1].num    = {1'b0, in_item.t};
        req_next[1].den    = {1'b0, in_item.det};
        req_next[1].force0 = 1'b0;
        req_next[1].force1 = !(in_item.t < in_item.det);
      end
    end else if (in_item.s[PROD_BITS-1]) begin
      side_next.region   = REG_VERT_C;
      req_next[1].force0 = 1'b0;
      req_next[1].force1 = 1'b1;
    end else if (in_item.t[PROD_BITS-1]) begin
      side_next.region   = REG_VERT_B;
      req_next[0].force0 = 1'b0;
      req_next[0].force1 = 1'b1;
    end else begin
      side_next.region     = REG_EDGE_BC;
      side_next.tw_from_sw = 1'b1;
      req_next[0].num    = {{(REM_BITS-SIX_BITS){1'b0}}, in_item.num6};
      req_next[0].den    = {{(REM_BITS-SIX_BITS){1'b0}}, in_item.den6};
      req_next[0].force0 = (in_item.den6 <= 0) || (in_item.num6 <= 0);
      // A degenerate far edge takes the zero weight even when num is not below den.
      req_next[0].force1 = !((in_item.den6 <= 0) || (in_item.num6 <= 0))
                        && !(in_item.num6 < in_item.den6);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_next;
      out_req  <= req_next;
    end
  end
endmodule

>>> design/ptcp_div.sv
// Two lanes of restoring division, one quotient bit per pipeline stage.
module ptcp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  ptcp_pkg::side_t           in_side,
  input  ptcp_pkg::lane_t [1:0]     in_req,
  output logic                      out_vld,
  output ptcp_pkg::side_t           out_side,
  output ptcp_pkg::quot_t [1:0]     out_quot
);
  import ptcp_pkg::*;

  logic [WFB-1:0]      vld;
  side_t               side_q [WFB];
  logic [REM_BITS-1:0] rem_q  [WFB][2];
  logic [REM_BITS-1:0] den_q  [WFB][2];
  logic [WFB-1:0]      quo_q  [WFB][2];
  logic                f0_q   [WFB][2];
  logic                f1_q   [WFB][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[WFB-2:0], in_vld};
    end
  end

  for (genvar i = 0; i < WFB; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk) if (en) side_q[i] <= in_side;
    end else begin : g_rest
      always_ff @(posedge clk) if (en) side_q[i] <= side_q[i-1];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [REM_BITS-1:0] rp, dp, sh;
      logic [WFB-1:0]      qp;
      logic                f0p, f1p, ge;
      if (i == 0) begin : g_src0
        assign rp  = in_req[l].num;
        assign dp  = in_req[l].den;
        assign qp  = '0;
        assign f0p = in_req[l].force0;
        assign f1p = in_req[l].force1;
      end else begin : g_srcn
        assign rp  = rem_q[i-1][l];
        assign dp  = den_q[i-1][l];
        assign qp  = quo_q[i-1][l];
        assign f0p = f0_q[i-1][l];
        assign f1p = f1_q[i-1][l];
      end
      assign sh = {rp[REM_BITS-2:0], 1'b0};
      assign ge = (sh >= dp);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i][l] <= ge ? sh - dp : sh;
          den_q[i][l] <= dp;
          quo_q[i][l] <= {qp[WFB-2:0], ge};
          f0_q[i][l]  <= f0p;
          f1_q[i][l]  <= f1p;
        end
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_out
    assign out_quot[l].q      = quo_q[WFB-1][l];
    assign out_quot[l].force0 = f0_q[WFB-1][l];
    assign out_quot[l].force1 = f1_q[WFB-1][l];
  end

  assign out_vld  = vld[WFB-1];
  assign out_side = side_q[WFB-1];
endmodule

>>> design/ptcp_blend.sv
// Output stage: weights applied to the edges and floored back to Q10.8.
module ptcp_blend (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  ptcp_pkg::side_t                      in_side,
  input  ptcp_pkg::quot_t [1:0]                in_quot,
  output logic                                 out_vld,
  output logic [2:0][ptcp_pkg::OUT_BITS-1:0]   out_near,
  output logic [2:0]                           out_region
);
  import ptcp_pkg::*;

  localparam logic [WT_BITS-1:0] ONE = WT_BITS'(1) << WFB;

  logic [WT_BITS-1:0] sw, tw_raw, tw;
  logic signed [ACC_BITS-1:0] acc [3];
  logic signed [ACC_BITS-1:0] shr [3];
  logic [2:0][OUT_BITS-1:0] near_next;

  function automatic logic [WT_BITS-1:0] weight(input quot_t qv);
    if (qv.force1) weight = ONE;
    else if (qv.force0) weight = '0;
    else weight = {1'b0, qv.q};
  endfunction

  always_comb begin
    sw     = weight(in_quot[0]);
    tw_raw = weight(in_quot[1]);
    tw     = in_side.tw_from_sw ? ONE - sw : tw_raw;
    for (int k = 0; k < 3; k++) begin
      acc[k] = (ACC_BITS'($signed(in_side.geom.a[k])) <<< WFB)
             + ACC_BITS'($signed({1'b0, sw})) * ACC_BITS'($signed(in_side.geom.e0[k]))
             + ACC_BITS'($signed({1'b0, tw})) * ACC_BITS'($signed(in_side.geom.e1[k]));
      shr[k] = acc[k] >>> WFB;
      near_next[k] = shr[k][OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_near   <= near_next;
      out_region <= in_side.region;
    end
  end

`ifndef ASSERT_OFF
  // The two weights never sum past one.
  a_wsum: assert property (@(posedge clk) disable iff (rst)
    in_vld |-> ({1'b0, sw} + {1'b0, tw}) <= {1'b0, ONE})
    else $error("weights sum above one");
  // On edge BC the weights sum to exactly one.
  a_bc: assert property (@(posedge clk) disable iff (rst)
    (in_vld && in_side.region == REG_EDGE_BC) |-> (sw + tw) == ONE)
    else $error("edge BC weights do not sum to one");
  // Vertex A takes no weight from either edge.
  a_va: assert property (@(posedge clk) disable iff (rst)
    (in_vld && in_side.region == REG_VERT_A) |-> (sw == '0 && tw == '0))
    else $error("vertex A with nonzero weight");
  // A stalled output keeps its region.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !en) |=> (out_vld && $stable(out_region)))
    else $error("stalled result changed");
`endif
endmodule

>>> design/point_triangle_closest_point_top.sv
// Top level of the closest-point-on-triangle pipeline.
//
//  channel   dir  handshake                  payload
//  s_        in   s_tvalid / s_tready        s_tdata: triangle and query point
//  m_        out  m_tvalid / m_tready        m_tdata: closest point, m_tuser: region
//  cfg_      in   cfg_valid / cfg_ready      cfg_data: determinant threshold
//
// One request enters per cycle while s_tready is high; each result passes one
// stage for the edge vectors, one for the dot products, one for the wide products,
// one for the determinant and numerators, one for the region choice, sixteen for
// the one-bit-per-stage dividers and one for the final weighted sum, in order.
// Reset clears every valid bit and sets the threshold to its default; no clearing
// pass is needed since the block keeps no memory.
// When m_tready is low with a result waiting, the whole pipeline holds in place and
// s_tready drops; empty stages hold as well, so bubbles are not squeezed out.
module point_triangle_closest_point_top (
  input  logic                               clk,
  input  logic                               rst,
  // Fields from bit 0 up: vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
  // vert_b_z, vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z.
  input  logic [ptcp_pkg::IN_BITS-1:0]       s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0 up: near_x, near_y, near_z, then two zero bits.
  output logic [ptcp_pkg::OUTD_BITS-1:0]     m_tdata,
  // Fields from bit 0 up: region.
  output logic [2:0]                         m_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [ptcp_pkg::THR_BITS-1:0]      cfg_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready
);
  import ptcp_pkg::*;

  logic [THR_BITS-1:0] thr;
  logic en;
  logic v_front, v_region, v_div;
  front_t f_item;
  side_t  r_side, d_side;
  lane_t [1:0] r_req;
  quot_t [1:0] d_quot;
  logic [2:0][OUT_BITS-1:0] near;

  // The pipeline moves whenever the output register is empty or being drained.
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  ptcp_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(s_tvalid), .in_data(s_tdata),
    .out_vld(v_front), .out_item(f_item)
  );

  ptcp_region u_region (
    .clk(clk), .rst(rst), .en(en), .thr(thr), .in_vld(v_front), .in_item(f_item),
    .out_vld(v_region), .out_side(r_side), .out_req(r_req)
  );

  ptcp_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(v_region), .in_side(r_side),
    .in_req(r_req), .out_vld(v_div), .out_side(d_side), .out_quot(d_quot)
  );

  ptcp_blend u_blend (
    .clk(clk), .rst(rst), .en(en), .in_vld(v_div), .in_side(d_side),
    .in_quot(d_quot), .out_vld(m_tvalid), .out_near(near), .out_region(m_tuser)
  );

  assign m_tdata = {{(OUTD_BITS-3*OUT_BITS){1'b0}}, near};
endmodule
